// ===== design/ccb_pkg.sv =====
// shared types, constants and arithmetic helpers for color_channel_extract_blend
// no dependencies
package ccb_pkg;

  localparam int PixW      = 8;
  localparam int NumW      = 10;
  localparam int ProdW     = 18;
  localparam int QuotW     = 8;
  localparam int NumLanes  = 4;
  localparam int DivStages = 4;
  localparam int NumStages = DivStages + 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegTarget    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFull      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEmpty     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNormalize = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaximize  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPerComp   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegAlpha     = 3'd6;

  localparam logic [NumW-1:0] DenSum  = 10'd765;
  localparam logic [NumW-1:0] DenComp = 10'd255;
  localparam logic [PixW:0]   PixMax  = 9'd255;

  // state of one lane's pair of long divisions
  typedef struct packed {
    logic [ProdW-1:0] rem_a;
    logic [ProdW-1:0] rem_b;
    logic [QuotW-1:0] q_a;
    logic [QuotW-1:0] q_b;
    logic [NumW-1:0]  den;
  } div_state_t;

  // match term: min(t,p) or max(0,t+p-255)
  function automatic logic [PixW-1:0] match_term(input logic [PixW-1:0] t,
                                                 input logic [PixW-1:0] p,
                                                 input logic maxm);
    logic [PixW:0] s;
    s = {1'b0, t} + {1'b0, p};
    if (maxm) begin
      match_term = (s > PixMax) ? PixW'(s - PixMax) : '0;
    end else begin
      match_term = (t < p) ? t : p;
    end
  endfunction

  // one restoring step on both divisions at quotient bit k
  function automatic div_state_t div_step(input div_state_t s, input int unsigned k);
    div_state_t r;
    logic [ProdW-1:0] sh;
    r  = s;
    sh = ProdW'(s.den) << k;
    if (s.rem_a >= sh) begin
      r.rem_a = s.rem_a - sh;
      r.q_a   = s.q_a | (QuotW'(1) << k);
    end
    if (s.rem_b >= sh) begin
      r.rem_b = s.rem_b - sh;
      r.q_b   = s.q_b | (QuotW'(1) << k);
    end
    return r;
  endfunction

endpackage

// ===== design/ccb_in_if.sv =====
// input pixel channel
// depends on ccb_pkg
interface ccb_in_if import ccb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] in_red;
  logic [PixW-1:0] in_green;
  logic [PixW-1:0] in_blue;
  logic [PixW-1:0] in_alpha;
  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

// ===== design/ccb_out_if.sv =====
// output pixel channel
// depends on ccb_pkg
interface ccb_out_if import ccb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] out_red;
  logic [PixW-1:0] out_green;
  logic [PixW-1:0] out_blue;
  logic [PixW-1:0] out_alpha;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

// ===== design/ccb_cfg_if.sv =====
// configuration write channel
// depends on ccb_pkg
interface ccb_cfg_if import ccb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/ccb_lane.sv =====
// one blend lane: product stage then a four-stage pipelined pair of dividers
// depends on ccb_pkg
module ccb_lane import ccb_pkg::*; (
  input  logic                 clk,
  input  logic [DivStages:0]   en,
  input  logic [NumW-1:0]      num,
  input  logic [NumW-1:0]      den,
  input  logic [PixW-1:0]      full,
  input  logic [PixW-1:0]      empty,
  output logic [PixW:0]        sum
);

  div_state_t st [0:DivStages];

  // products full*num and empty*(den-num)
  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0].rem_a <= ProdW'(full) * ProdW'(num);
      st[0].rem_b <= ProdW'(empty) * ProdW'(den - num);
      st[0].q_a   <= '0;
      st[0].q_b   <= '0;
      st[0].den   <= den;
    end
  end

  // two quotient bits per stage, msb first
  for (genvar j = 0; j < DivStages; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        st[j+1] <= div_step(div_step(st[j], 7 - 2*j), 6 - 2*j);
      end
    end
  end

  assign sum = {1'b0, st[DivStages].q_a} + {1'b0, st[DivStages].q_b};

endmodule

// ===== design/color_channel_extract_blend.sv =====
// top level of the color match blend pipeline
// depends on ccb_pkg, ccb_in_if, ccb_out_if, ccb_cfg_if, ccb_lane
//
// usage:
//   pix_in  carries one RGBA pixel per request, pix_out one blended pixel.
//   cfg     writes the seven registers by index; it is always ready and
//           should be written only while no pixel is in flight.
//   an accepted input passes through a match stage, a product stage, four
//   divider stages (two quotient bits each) and the output register.
//   throughput is one pixel per clock while the receiver is ready; every
//   stage holds its own valid bit, so a stalled receiver only freezes the
//   stages that are full, and empty stages keep taking requests until the
//   pipeline fills.
//   rst (synchronous, active high) empties the pipeline and loads the
//   register defaults: target 0, full and empty 255, normalize on,
//   maximize off, summed mode, alpha present.
//   nothing is lost or repeated under backpressure.
module color_channel_extract_blend import ccb_pkg::*; (
  input logic       clk,
  input logic       rst,
  ccb_in_if.sink    pix_in,
  ccb_out_if.source pix_out,
  ccb_cfg_if.sink   cfg
);

  logic [23:0]         target_color;
  logic [31:0]         full_color;
  logic [31:0]         empty_color;
  logic                normalize_enable;
  logic                maximize_mode;
  logic                split_mode;
  logic                alpha_present;

  logic [NumStages-1:0] v;
  logic [NumStages:0]   en;

  logic [PixW-1:0]     tgt [0:2];
  logic [PixW-1:0]     pix [0:2];
  logic [PixW-1:0]     term [0:2];
  logic [NumW-1:0]     num_sum;
  logic [NumW-1:0]     den_sum;
  logic [NumW-1:0]     num_next [0:NumLanes-1];
  logic [NumW-1:0]     den_next [0:NumLanes-1];

  logic [NumW-1:0]     num_q [0:NumLanes-1];
  logic [NumW-1:0]     den_q [0:NumLanes-1];
  logic [PixW-1:0]     full_q [0:NumLanes-1];
  logic [PixW-1:0]     empty_q [0:NumLanes-1];
  logic [PixW-1:0]     alpha_q [0:NumStages-2];
  logic                pass_q [0:NumStages-2];
  logic [PixW:0]       lane_sum [0:NumLanes-1];
  logic [PixW-1:0]     res [0:NumLanes-1];

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      target_color     <= '0;
      full_color       <= 32'd255;
      empty_color      <= 32'd255;
      normalize_enable <= 1'b1;
      maximize_mode    <= 1'b0;
      split_mode       <= 1'b0;
      alpha_present    <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegTarget:    target_color     <= cfg.data[23:0];
        RegFull:      full_color       <= cfg.data;
        RegEmpty:     empty_color      <= cfg.data;
        RegNormalize: normalize_enable <= cfg.data[0];
        RegMaximize:  maximize_mode    <= cfg.data[0];
        RegPerComp:   split_mode       <= cfg.data[0];
        RegAlpha:     alpha_present    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NumStages] = pix_out.ready;
    for (int i = NumStages - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end
  assign pix_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= pix_in.valid;
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // match terms and denominators
  always_comb begin
    tgt[0] = target_color[23:16];
    tgt[1] = target_color[15:8];
    tgt[2] = target_color[7:0];
    pix[0] = pix_in.in_red;
    pix[1] = pix_in.in_green;
    pix[2] = pix_in.in_blue;
    num_sum = '0;
    den_sum = '0;
    for (int c = 0; c < 3; c++) begin
      term[c] = match_term(tgt[c], pix[c], maximize_mode);
      num_sum = num_sum + NumW'(term[c]);
      den_sum = den_sum + NumW'(tgt[c]);
    end
    if (!normalize_enable) begin
      den_sum = DenSum;
    end else if (den_sum == '0) begin
      den_sum = NumW'(1);
    end
    for (int c = 0; c < 3; c++) begin
      if (split_mode) begin
        num_next[c] = NumW'(term[c]);
        if (!normalize_enable) den_next[c] = DenComp;
        else if (tgt[c] == '0) den_next[c] = NumW'(1);
        else den_next[c] = NumW'(tgt[c]);
      end else begin
        num_next[c] = num_sum;
        den_next[c] = den_sum;
      end
    end
    num_next[3] = num_sum;
    den_next[3] = den_sum;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < NumLanes; l++) begin
        num_q[l]   <= num_next[l];
        den_q[l]   <= den_next[l];
        full_q[l]  <= full_color[31-8*l -: 8];
        empty_q[l] <= empty_color[31-8*l -: 8];
      end
    end
  end

  // alpha passthrough travels beside the lanes
  always_ff @(posedge clk) begin
    if (en[0]) begin
      alpha_q[0] <= pix_in.in_alpha;
      pass_q[0]  <= split_mode || !alpha_present;
    end
    for (int i = 1; i < NumStages - 1; i++) begin
      if (en[i]) begin
        alpha_q[i] <= alpha_q[i-1];
        pass_q[i]  <= pass_q[i-1];
      end
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    ccb_lane u_lane (
      .clk   (clk),
      .en    (en[DivStages+1:1]),
      .num   (num_q[l]),
      .den   (den_q[l]),
      .full  (full_q[l]),
      .empty (empty_q[l]),
      .sum   (lane_sum[l])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[NumStages-1]) begin
      for (int l = 0; l < NumLanes - 1; l++) begin
        res[l] <= lane_sum[l][PixW-1:0];
      end
      res[3] <= pass_q[NumStages-2] ? alpha_q[NumStages-2] : lane_sum[3][PixW-1:0];
    end
  end

  assign pix_out.valid     = v[NumStages-1];
  assign pix_out.out_red   = res[0];
  assign pix_out.out_green = res[1];
  assign pix_out.out_blue  = res[2];
  assign pix_out.out_alpha = res[3];

  // an empty output register never blocks the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !v[NumStages-1] |-> pix_in.ready) else $error("input blocked with output empty");

  // match never exceeds its denominator
  a_num_le_den: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> (num_q[0] <= den_q[0] && num_q[1] <= den_q[1] &&
              num_q[2] <= den_q[2] && num_q[3] <= den_q[3]))
    else $error("match exceeds denominator");

  // blended value fits a byte
  a_sum_fits: assert property (@(posedge clk) disable iff (rst)
    v[NumStages-2] |-> (!lane_sum[0][PixW] && !lane_sum[1][PixW] &&
                        !lane_sum[2][PixW] && !lane_sum[3][PixW]))
    else $error("blend overflow");

endmodule

// ===== tb/tb_top.sv =====
// testbench for color_channel_extract_blend: random and directed pixels checked
// against a behavioral predictor of the match blend
// depends on ccb_pkg, ccb_in_if, ccb_out_if, ccb_cfg_if and the block itself
module tb_top import ccb_pkg::*; ();

  typedef struct {
    logic [7:0] r, g, b, a;
  } pixel_t;

  // predicts the blended pixel and holds the expected results in order
  class blend_scoreboard;
    logic [23:0] target;
    logic [31:0] full;
    logic [31:0] empty;
    bit normalize, maximize, per_comp, alpha_on;
    pixel_t expected_q[$];
    int errors;

    function new();
      target = 0; full = 255; empty = 255;
      normalize = 1; maximize = 0; per_comp = 0; alpha_on = 1;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
      case (idx)
        RegTarget:    target = v[23:0];
        RegFull:      full = v;
        RegEmpty:     empty = v;
        RegNormalize: normalize = v[0];
        RegMaximize:  maximize = v[0];
        RegPerComp:   per_comp = v[0];
        RegAlpha:     alpha_on = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned term(int unsigned t, int unsigned p);
      if (maximize) return (t + p > 255) ? t + p - 255 : 0;
      return (t < p) ? t : p;
    endfunction

    function logic [7:0] mix(int unsigned f, int unsigned e, int unsigned n, int unsigned d);
      int unsigned s;
      s = (f * n) / d + (e * (d - n)) / d;
      return s[7:0];
    endfunction

    // note an accepted input pixel
    function void note_input(pixel_t p);
      int unsigned t[3], px[3], res[4];
      int unsigned n, d;
      pixel_t o;
      t[0] = target[23:16]; t[1] = target[15:8]; t[2] = target[7:0];
      px[0] = p.r; px[1] = p.g; px[2] = p.b;
      if (per_comp) begin
        for (int c = 0; c < 3; c++) begin
          n = term(t[c], px[c]);
          d = normalize ? ((t[c] != 0) ? t[c] : 1) : 255;
          res[c] = mix(full[31-8*c -: 8], empty[31-8*c -: 8], n, d);
        end
        res[3] = p.a;
      end else begin
        n = 0;
        for (int c = 0; c < 3; c++) n += term(t[c], px[c]);
        d = normalize ? t[0] + t[1] + t[2] : 765;
        if (d == 0) d = 1;
        for (int c = 0; c < 3; c++)
          res[c] = mix(full[31-8*c -: 8], empty[31-8*c -: 8], n, d);
        res[3] = alpha_on ? mix(full[7:0], empty[7:0], n, d) : p.a;
      end
      o.r = res[0][7:0]; o.g = res[1][7:0]; o.b = res[2][7:0]; o.a = res[3][7:0];
      expected_q.push_back(o);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(pixel_t got);
      pixel_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result %h %h %h %h", got.r, got.g, got.b, got.a);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.r !== e.r) begin $error("out_red exp %h got %h", e.r, got.r); errors++; end
      if (got.g !== e.g) begin $error("out_green exp %h got %h", e.g, got.g); errors++; end
      if (got.b !== e.b) begin $error("out_blue exp %h got %h", e.b, got.b); errors++; end
      if (got.a !== e.a) begin $error("out_alpha exp %h got %h", e.a, got.a); errors++; end
    endfunction
  endclass

  localparam int WatchLimit = 5000;
  // an index past the last register, whose writes are dropped
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic clk = 0;
  logic rst = 1;
  bit   no_idle = 0;
  int   idle_cnt = 0;
  blend_scoreboard sb;

  ccb_in_if  pix_in();
  ccb_out_if pix_out();
  ccb_cfg_if cfg();

  color_channel_extract_blend dut (.clk(clk), .rst(rst), .pix_in(pix_in),
                                   .pix_out(pix_out), .cfg(cfg));

  always #1 clk = ~clk;

  initial begin
    sb = new();
    pix_in.valid = 0; pix_in.in_red = 0; pix_in.in_green = 0;
    pix_in.in_blue = 0; pix_in.in_alpha = 0;
    pix_out.ready = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
  end

  // receiver side: random stalls, checks on accepted results
  always @(negedge clk) begin
    if (!rst) pix_out.ready <= no_idle || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    pixel_t got;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got.r = pix_out.out_red; got.g = pix_out.out_green;
      got.b = pix_out.out_blue; got.a = pix_out.out_alpha;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
        || (cfg.valid && cfg.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg.valid <= 0;
    @(negedge clk);
  endtask

  // send one pixel, with a random gap before it; valid stays up afterwards
  task automatic send_pixel(pixel_t p);
    while (!no_idle && $urandom_range(99) < 30) begin
      pix_in.valid <= 0;
      @(negedge clk);
    end
    pix_in.valid <= 1;
    pix_in.in_red <= p.r; pix_in.in_green <= p.g;
    pix_in.in_blue <= p.b; pix_in.in_alpha <= p.a;
    do @(posedge clk); while (!pix_in.ready);
    sb.note_input(p);
    @(negedge clk);
  endtask

  task automatic drain();
    pix_in.valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (NumStages + 3) @(negedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    case ($urandom_range(5))
      0: begin p.r = 8'd0; p.g = 8'd0; p.b = 8'd0; end
      1: begin p.r = 8'd255; p.g = 8'd255; p.b = 8'd255; end
      default: begin p.r = 8'($urandom); p.g = 8'($urandom); p.b = 8'($urandom); end
    endcase
    p.a = 8'($urandom);
    return p;
  endfunction

  task automatic set_mode(bit n, bit m, bit pc, bit a);
    write_reg(RegNormalize, 32'(n));
    write_reg(RegMaximize, 32'(m));
    write_reg(RegPerComp, 32'(pc));
    write_reg(RegAlpha, 32'(a));
  endtask

  initial begin
    pixel_t p;
    logic [31:0] tv;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: reset defaults with zero target, then extremes in every mode
    for (int i = 0; i < 2; i++) begin
      p.r = i ? 8'd255 : 8'd0; p.g = p.r; p.b = p.r; p.a = i ? 8'd0 : 8'd255;
      send_pixel(p);
    end
    drain();
    write_reg(RegTarget, 32'hFFFFFFFF);
    write_reg(RegFull, 32'hFFFFFFFF);
    write_reg(RegEmpty, 32'h00000000);
    write_reg(RegUnused, 32'h1);
    for (int mode = 0; mode < 16; mode++) begin
      set_mode(mode[0], mode[1], mode[2], mode[3]);
      p.r = mode[0] ? 8'd255 : 8'd0; p.g = 8'd128; p.b = mode[1] ? 8'd0 : 8'd255;
      p.a = 8'hA5;
      send_pixel(p);
      drain();
    end

    // random phases: new settings each phase, the second phase with no idling
    for (int ph = 0; ph < 30; ph++) begin
      no_idle = (ph == 1);
      case ($urandom_range(3))
        0: tv = 0;
        1: tv = 32'hFFFFFFFF;
        default: tv = $urandom;
      endcase
      write_reg(RegTarget, tv);
      write_reg(RegFull, ($urandom_range(4) == 0) ? 32'hFFFFFFFF : $urandom);
      write_reg(RegEmpty, ($urandom_range(4) == 0) ? 32'h0 : $urandom);
      set_mode(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      for (int i = 0; i < 64; i++) send_pixel(rand_pixel());
      drain();
    end
    no_idle = 0;

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
